// ===== rtl/stl_pkg.sv =====
// ----------------------------------------------------------------------------
// stl_pkg
// Shared types, constants and character classes for the source token lexer.
// ----------------------------------------------------------------------------
package stl_pkg;

  localparam int WORD_KEEP   = 8;
  localparam int LINE_BITS   = 16;
  localparam int LINE_OUT_W  = 16;
  localparam int LINE_EXT_W  = (LINE_BITS > LINE_OUT_W) ? LINE_BITS : LINE_OUT_W;
  localparam int WORD_IDX_W  = (WORD_KEEP > 1) ? $clog2(WORD_KEEP) : 1;
  localparam int WORD_LEN_W  = $clog2(WORD_KEEP + 2);
  localparam int KIND_W      = 6;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [LINE_BITS-1:0] LINE_TOP = {LINE_BITS{1'b1}};

  localparam logic [KIND_W-1:0] K_END    = 6'd0;
  localparam logic [KIND_W-1:0] K_OR     = 6'd12;
  localparam logic [KIND_W-1:0] K_STRLIT = 6'd24;
  localparam logic [KIND_W-1:0] K_NUMBER = 6'd25;
  localparam logic [KIND_W-1:0] K_IDENT  = 6'd26;
  localparam logic [KIND_W-1:0] K_RETURN = 6'd33;

  typedef logic [WORD_KEEP-1:0][7:0] word_t;

  typedef struct packed {
    logic [KIND_W-1:0]     kind;
    logic [LINE_OUT_W-1:0] line;
    logic                  last;
  } token_t;

  // front to queue
  typedef struct packed {
    logic [1:0] cnt;
    token_t     t0;
    token_t     t1;
  } push_t;

  // queue head to back
  typedef struct packed {
    logic   valid;
    token_t tok;
  } head_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_digit(c) || ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic [7:0] low_case(input logic [7:0] c);
    return ((c >= "A") && (c <= "Z")) ? c + 8'd32 : c;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0a) || (c == 8'h0b) ||
           (c == 8'h0c) || (c == 8'h0d);
  endfunction

  // single punctuators, zero when not one
  function automatic logic [KIND_W-1:0] punct_kind(input logic [7:0] c);
    case (c)
      "{":     return 6'd1;
      "}":     return 6'd2;
      ";":     return 6'd3;
      "(":     return 6'd4;
      ")":     return 6'd5;
      "+":     return 6'd6;
      "-":     return 6'd7;
      "/":     return 6'd8;
      "*":     return 6'd9;
      "%":     return 6'd10;
      ",":     return 6'd11;
      default: return 6'd0;
    endcase
  endfunction

  // operator that may pair; index 0..5, bit 3 set when not one
  function automatic logic [3:0] op_index(input logic [7:0] c);
    case (c)
      "|":     return 4'd0;
      "&":     return 4'd1;
      "=":     return 4'd2;
      "<":     return 4'd3;
      ">":     return 4'd4;
      "!":     return 4'd5;
      default: return 4'b1000;
    endcase
  endfunction

  function automatic logic [7:0] op_mate(input logic [2:0] op);
    case (op)
      3'd0:    return "|";
      3'd1:    return "&";
      default: return "=";
    endcase
  endfunction

  function automatic logic [63:0] kw_text(input logic [3:0] k);
    case (k)
      4'd0:    return 64'("if");
      4'd1:    return 64'("while");
      4'd2:    return 64'("function");
      4'd3:    return 64'("string");
      4'd4:    return 64'("double");
      4'd5:    return 64'("call");
      4'd6:    return 64'("even");
      4'd7:    return 64'("input");
      4'd8:    return 64'("print");
      4'd9:    return 64'("endif");
      4'd10:   return 64'("done");
      default: return 64'("return");
    endcase
  endfunction

  function automatic logic [3:0] kw_len(input logic [3:0] k);
    case (k)
      4'd0:                      return 4'd2;
      4'd1, 4'd7, 4'd8, 4'd9:    return 4'd5;
      4'd2:                      return 4'd8;
      4'd3, 4'd4, 4'd11:         return 4'd6;
      default:                   return 4'd4;
    endcase
  endfunction

  function automatic logic [KIND_W-1:0] kw_kind(input logic [3:0] k);
    case (k)
      4'd6, 4'd11: return K_RETURN;
      4'd7:        return 6'd34;
      4'd8:        return 6'd35;
      4'd9:        return 6'd36;
      4'd10:       return 6'd37;
      default:     return 6'(27 + int'(k));
    endcase
  endfunction

  // classify a finished word
  function automatic logic [KIND_W-1:0] word_kind(input word_t w,
                                                  input logic [WORD_LEN_W-1:0] n);
    logic [7:0]        a;
    logic [7:0]        b;
    logic [7:0]        c;
    logic [63:0]       txt;
    logic [3:0]        len;
    logic              hit;
    logic [KIND_W-1:0] res;
    a   = low_case(w[0]);
    b   = low_case(w[1]);
    c   = low_case(w[2]);
    res = K_IDENT;
    for (int k = 11; k >= 0; k--) begin
      txt = kw_text(4'(k));
      len = kw_len(4'(k));
      hit = (WORD_LEN_W'(len) == n);
      for (int i = 0; i < 8; i++) begin
        if (i < int'(len) && w[i] != txt[8*(int'(len)-1-i) +: 8]) hit = 1'b0;
      end
      if (hit) res = kw_kind(4'(k));
    end
    if (is_digit(a)) res = K_NUMBER;
    if ((a == ".") && (n >= WORD_LEN_W'(2)) && is_digit(w[1])) res = K_NUMBER;
    if ((n >= WORD_LEN_W'(3)) &&
        (((a == "i") && (b == "n") && (c == "f")) ||
         ((a == "n") && (b == "a") && (c == "n")))) res = K_NUMBER;
    return res;
  endfunction

  function automatic logic [LINE_OUT_W-1:0] sat_line(input logic [LINE_BITS-1:0] ln);
    logic [LINE_EXT_W-1:0] ext;
    ext = LINE_EXT_W'(ln);
    if (ext > LINE_EXT_W'({LINE_OUT_W{1'b1}})) return {LINE_OUT_W{1'b1}};
    return ext[LINE_OUT_W-1:0];
  endfunction

endpackage

// ===== rtl/stl_in_if.sv =====
// ----------------------------------------------------------------------------
// stl_in_if
// Source byte channel: one byte or an end marker per item.
// ----------------------------------------------------------------------------
interface stl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_text;

  modport source (output valid, ch, end_of_text, input ready);
  modport sink   (input valid, ch, end_of_text, output ready);
endinterface

// ===== rtl/stl_tok_if.sv =====
// ----------------------------------------------------------------------------
// stl_tok_if
// Token channel: token kind, line number and last-of-item flag.
// ----------------------------------------------------------------------------
interface stl_tok_if;
  logic                           valid;
  logic                           ready;
  logic [stl_pkg::KIND_W-1:0]     token_kind;
  logic [stl_pkg::LINE_OUT_W-1:0] line;
  logic                           last;

  modport source (output valid, token_kind, line, last, input ready);
  modport sink   (input valid, token_kind, line, last, output ready);
endinterface

// ===== rtl/stl_front.sv =====
// ----------------------------------------------------------------------------
// stl_front
// Lexer state machine: takes bytes, keeps the word buffer and line count,
// and pushes zero, one or two tokens per item into the queue.
// ----------------------------------------------------------------------------
module stl_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              valid,
  output logic              ready,
  input  logic [7:0]        ch,
  input  logic              end_of_text,
  input  logic              room,
  output stl_pkg::push_t    push
);

  typedef enum logic [1:0] {IDLE, OP, STR, WORD} mode_t;

  mode_t                               mode, mode_next;
  logic [2:0]                          pending_op, pending_op_next;
  logic                                quote_char, quote_char_next;
  logic [stl_pkg::WORD_LEN_W-1:0]      word_length, word_length_next;
  logic [stl_pkg::LINE_BITS-1:0]       line_count, line_count_next;
  logic [stl_pkg::LINE_BITS-1:0]       token_line, token_line_next;
  logic [7:0]                          word_chars [stl_pkg::WORD_KEEP];

  stl_pkg::word_t                      word_vec;
  logic                                wr_en;
  logic [stl_pkg::WORD_IDX_W-1:0]      wr_idx;
  logic                                accept;
  logic                                is_end;
  logic [2:0]                          op;
  logic                                run_idle;
  logic                                pre_v, post_v;
  logic [stl_pkg::KIND_W-1:0]          pre_kind, post_kind;
  logic [stl_pkg::LINE_BITS-1:0]       pre_line, post_line;
  logic [stl_pkg::KIND_W-1:0]          punct;
  logic [3:0]                          opi;
  logic [stl_pkg::KIND_W-1:0]          wkind;
  logic [stl_pkg::KIND_W-1:0]          op_single;

  assign ready  = room;
  assign accept = valid && ready;
  assign is_end = end_of_text || (ch == 8'h00);
  assign op     = (pending_op < 3'd6) ? pending_op : 3'd0;
  assign punct  = stl_pkg::punct_kind(ch);
  assign opi    = stl_pkg::op_index(ch);
  assign op_single = stl_pkg::K_OR + {2'b00, op, 1'b0};

  always_comb begin
    for (int i = 0; i < stl_pkg::WORD_KEEP; i++) word_vec[i] = word_chars[i];
  end

  assign wkind = stl_pkg::word_kind(word_vec, word_length);

  always_comb begin
    mode_next        = mode;
    pending_op_next  = pending_op;
    quote_char_next  = quote_char;
    word_length_next = word_length;
    line_count_next  = line_count;
    token_line_next  = token_line;
    wr_en            = 1'b0;
    wr_idx           = '0;
    run_idle         = 1'b0;
    pre_v            = 1'b0;
    pre_kind         = stl_pkg::K_END;
    pre_line         = token_line;
    post_v           = 1'b0;
    post_kind        = stl_pkg::K_END;
    post_line        = line_count;

    if (is_end) begin
      mode_next = IDLE;
      post_v    = 1'b1;
      case (mode)
        OP: begin
          pre_v    = 1'b1;
          pre_kind = op_single;
        end
        STR: begin
          pre_v    = 1'b1;
          pre_kind = stl_pkg::K_STRLIT;
        end
        WORD: begin
          pre_v    = 1'b1;
          pre_kind = wkind;
        end
        default: ;
      endcase
    end else begin
      case (mode)
        OP: begin
          mode_next = IDLE;
          pre_v     = 1'b1;
          if (ch == stl_pkg::op_mate(op)) begin
            pre_kind = op_single + 6'd1;
          end else begin
            pre_kind = op_single;
            run_idle = 1'b1;
          end
        end
        STR: begin
          if (ch == (quote_char ? 8'h27 : 8'h22)) begin
            pre_v     = 1'b1;
            pre_kind  = stl_pkg::K_STRLIT;
            mode_next = IDLE;
          end else if (ch == 8'h0a && line_count < stl_pkg::LINE_TOP) begin
            line_count_next = line_count + 1'b1;
          end
        end
        WORD: begin
          if (stl_pkg::is_alnum(ch)) begin
            // keep the first bytes, length saturates one past the buffer
            if (word_length < stl_pkg::WORD_LEN_W'(stl_pkg::WORD_KEEP)) begin
              wr_en  = 1'b1;
              wr_idx = word_length[stl_pkg::WORD_IDX_W-1:0];
            end
            if (word_length <= stl_pkg::WORD_LEN_W'(stl_pkg::WORD_KEEP))
              word_length_next = word_length + 1'b1;
          end else begin
            pre_v     = 1'b1;
            pre_kind  = wkind;
            mode_next = IDLE;
            run_idle  = 1'b1;
          end
        end
        default: begin
          mode_next = IDLE;
          run_idle  = 1'b1;
        end
      endcase

      if (run_idle) begin
        if (stl_pkg::is_space(ch)) begin
          if (ch == 8'h0a && line_count < stl_pkg::LINE_TOP)
            line_count_next = line_count + 1'b1;
        end else begin
          token_line_next = line_count;
          if (punct != stl_pkg::K_END) begin
            post_v    = 1'b1;
            post_kind = punct;
          end else if (!opi[3]) begin
            mode_next       = OP;
            pending_op_next = opi[2:0];
          end else if (ch == 8'h22 || ch == 8'h27) begin
            mode_next       = STR;
            quote_char_next = (ch == 8'h27);
          end else begin
            mode_next        = WORD;
            wr_en            = 1'b1;
            wr_idx           = '0;
            word_length_next = stl_pkg::WORD_LEN_W'(1);
          end
        end
      end
    end
  end

  // token slots toward the queue
  always_comb begin
    push.t0.kind = pre_v ? pre_kind : post_kind;
    push.t0.line = stl_pkg::sat_line(pre_v ? pre_line : post_line);
    push.t0.last = !(pre_v && post_v);
    push.t1.kind = post_kind;
    push.t1.line = stl_pkg::sat_line(post_line);
    push.t1.last = 1'b1;
    push.cnt     = accept ? ({1'b0, pre_v} + {1'b0, post_v}) : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= IDLE;
      pending_op  <= '0;
      quote_char  <= 1'b0;
      word_length <= '0;
      line_count  <= '0;
      token_line  <= '0;
    end else if (accept) begin
      mode        <= mode_next;
      pending_op  <= pending_op_next;
      quote_char  <= quote_char_next;
      word_length <= word_length_next;
      line_count  <= line_count_next;
      token_line  <= token_line_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && wr_en) word_chars[wr_idx] <= ch;
  end

endmodule

// ===== rtl/stl_queue.sv =====
// ----------------------------------------------------------------------------
// stl_queue
// Short token queue: up to two writes and one read per cycle.
// ----------------------------------------------------------------------------
module stl_queue (
  input  logic           clk,
  input  logic           rst,
  input  stl_pkg::push_t push,
  input  logic           pop,
  output stl_pkg::head_t head,
  output logic           room
);

  stl_pkg::token_t                 slots [stl_pkg::QUEUE_DEPTH];
  logic [stl_pkg::QUEUE_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [stl_pkg::QUEUE_CNT_W-1:0] count;
  logic [stl_pkg::QUEUE_PTR_W-1:0] wr_ptr1;

  assign wr_ptr1    = wr_ptr + 1'b1;
  assign head.valid = (count != '0);
  assign head.tok   = slots[rd_ptr];
  // two free entries so a two-token item always fits
  assign room       = (count <= stl_pkg::QUEUE_CNT_W'(stl_pkg::QUEUE_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + stl_pkg::QUEUE_PTR_W'(push.cnt);
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + stl_pkg::QUEUE_CNT_W'(push.cnt) - stl_pkg::QUEUE_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) slots[wr_ptr] <= push.t0;
    if (push.cnt == 2'd2) slots[wr_ptr1] <= push.t1;
  end

endmodule

// ===== rtl/stl_back.sv =====
// ----------------------------------------------------------------------------
// stl_back
// Output register: drains the queue head onto the token channel.
// ----------------------------------------------------------------------------
module stl_back (
  input  logic           clk,
  input  logic           rst,
  input  stl_pkg::head_t head,
  output logic           pop,
  output logic           valid,
  input  logic           ready,
  output stl_pkg::token_t tok
);

  assign pop = head.valid && (!valid || ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!valid || ready) begin
      valid <= head.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) tok <= head.tok;
  end

endmodule

// ===== rtl/source_token_lexer.sv =====
// ----------------------------------------------------------------------------
// source_token_lexer
// Streaming lexer: source bytes in, token kinds with line numbers out.
// ----------------------------------------------------------------------------
// chars carries one source byte per item, or an end marker (end_of_text set,
// or a NUL byte) that flushes any pending token and then gives END.
// tokens carries token_kind, line (newlines before the token's first byte,
// saturating) and last, set on the final token that an item causes.
// An item causes zero, one or two tokens.
// Tokens pass through the token queue and then the output register before
// they appear on tokens. Throughput is one item per cycle while items give at
// most one token each and the receiver does not stall; a two-token item's tokens
// leave one at a time through the single output register draining a four-entry token queue.
// chars.ready drops while the queue has fewer than two free entries, so a
// stalled receiver fills the queue and then holds the input back; no token
// is dropped. Reset clears the lexer to idle between tokens, the line count
// to zero and empties the queue; it takes effect at the next clock edge.
// ----------------------------------------------------------------------------
module source_token_lexer (
  input  logic       clk,
  input  logic       rst,
  stl_in_if.sink     chars,
  stl_tok_if.source  tokens
);

  stl_pkg::push_t  push;
  stl_pkg::head_t  head;
  stl_pkg::token_t tok;
  logic            room;
  logic            pop;

  stl_front u_front (
    .clk         (clk),
    .rst         (rst),
    .valid       (chars.valid),
    .ready       (chars.ready),
    .ch          (chars.ch),
    .end_of_text (chars.end_of_text),
    .room        (room),
    .push        (push)
  );

  stl_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .head (head),
    .room (room)
  );

  stl_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .pop   (pop),
    .valid (tokens.valid),
    .ready (tokens.ready),
    .tok   (tok)
  );

  assign tokens.token_kind = tok.kind;
  assign tokens.line       = tok.line;
  assign tokens.last       = tok.last;

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Streams source bytes into the token lexer with random gaps and output
// stalls, predicts every token kind, line and last flag in step with the
// accepted items, and compares each token with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [stl_pkg::KIND_W-1:0] KW_IF       = 6'd27;
  localparam logic [stl_pkg::KIND_W-1:0] KW_WHILE    = 6'd28;
  localparam logic [stl_pkg::KIND_W-1:0] KW_FUNCTION = 6'd29;
  localparam logic [stl_pkg::KIND_W-1:0] KW_STRING   = 6'd30;
  localparam logic [stl_pkg::KIND_W-1:0] KW_DOUBLE   = 6'd31;
  localparam logic [stl_pkg::KIND_W-1:0] KW_CALL     = 6'd32;
  localparam logic [stl_pkg::KIND_W-1:0] KW_INPUT    = 6'd34;
  localparam logic [stl_pkg::KIND_W-1:0] KW_PRINT    = 6'd35;
  localparam logic [stl_pkg::KIND_W-1:0] KW_ENDIF    = 6'd36;
  localparam logic [stl_pkg::KIND_W-1:0] KW_DONE     = 6'd37;
  localparam logic [7:0]                 NL          = 8'h0a;
  localparam logic [7:0]                 NUL         = 8'h00;

  typedef enum logic [1:0] {LEX_IDLE, LEX_OP, LEX_STR, LEX_WORD} lex_mode_e;

  logic clk;
  logic rst;

  stl_in_if  chars_if ();
  stl_tok_if tok_if ();

  source_token_lexer uut (
    .clk    (clk),
    .rst    (rst),
    .chars  (chars_if),
    .tokens (tok_if)
  );

  logic [7:0]        punct_ch [11] = '{"{", "}", ";", "(", ")", "+", "-", "/", "*", "%", ","};
  logic [7:0]        op_ch [6]     = '{"|", "&", "=", "<", ">", "!"};
  logic [7:0]        op_mate_ch [6] = '{"|", "&", "=", "=", "=", "="};
  logic [7:0]        blank_ch [6]  = '{8'h20, 8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0d};
  string             kw_words [12] = '{"if", "while", "function", "string", "double",
                                       "call", "even", "input", "print", "endif",
                                       "done", "return"};
  logic [stl_pkg::KIND_W-1:0] kw_kinds [12] = '{KW_IF, KW_WHILE, KW_FUNCTION, KW_STRING,
                                                KW_DOUBLE, KW_CALL, stl_pkg::K_RETURN,
                                                KW_INPUT, KW_PRINT, KW_ENDIF, KW_DONE,
                                                stl_pkg::K_RETURN};

  // lexer state as predicted
  lex_mode_e                     lex_mode;
  logic [2:0]                    op_held;
  logic                          quote_single;
  logic [7:0]                    word_buf [stl_pkg::WORD_KEEP];
  int                            word_len;
  logic [stl_pkg::LINE_BITS-1:0] line_count;
  logic [stl_pkg::LINE_BITS-1:0] token_line;

  stl_pkg::token_t tokens_due [$];
  stl_pkg::token_t item_tokens [$];
  int              errors;
  int              items_sent;
  bit              quiet;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4ms;
    $display("Test completed with failures");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    $display("%0t mismatch %s: got %0d want %0d", $time, what, got, want);
  endtask

  function automatic bit is_num(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_alnum_ch(input logic [7:0] c);
    return is_num(c) || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic bit is_blank(input logic [7:0] c);
    int k;
    for (k = 0; k < 6; k++) if (blank_ch[k] == c) return 1'b1;
    return 1'b0;
  endfunction

  function automatic logic [stl_pkg::KIND_W-1:0] classify_word();
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
    bit         hit;
    int         k;
    int         i;
    a = to_lower(word_buf[0]);
    if (is_num(a)) return stl_pkg::K_NUMBER;
    if (a == "." && word_len >= 2 && is_num(word_buf[1])) return stl_pkg::K_NUMBER;
    if (word_len >= 3) begin
      b = to_lower(word_buf[1]);
      c = to_lower(word_buf[2]);
      if ((a == "i" && b == "n" && c == "f") || (a == "n" && b == "a" && c == "n"))
        return stl_pkg::K_NUMBER;
    end
    if (word_len <= stl_pkg::WORD_KEEP) begin
      for (k = 0; k < 12; k++) begin
        if (kw_words[k].len() == word_len) begin
          hit = 1'b1;
          for (i = 0; i < word_len; i++) if (word_buf[i] != kw_words[k][i]) hit = 1'b0;
          if (hit) return kw_kinds[k];
        end
      end
    end
    return stl_pkg::K_IDENT;
  endfunction

  task automatic add_token(input logic [stl_pkg::KIND_W-1:0] kind,
                           input logic [stl_pkg::LINE_BITS-1:0] ln);
    stl_pkg::token_t t;
    t.kind = kind;
    t.line = (ln > stl_pkg::LINE_BITS'({stl_pkg::LINE_OUT_W{1'b1}})) ?
             {stl_pkg::LINE_OUT_W{1'b1}} : stl_pkg::LINE_OUT_W'(ln);
    t.last = 1'b0;
    item_tokens.push_back(t);
  endtask

  task automatic add_to_word(input logic [7:0] c);
    if (word_len < stl_pkg::WORD_KEEP) word_buf[word_len] = c;
    if (word_len <= stl_pkg::WORD_KEEP) word_len++;
  endtask

  // first byte of a token, or whitespace between tokens
  task automatic start_token(input logic [7:0] c);
    int k;
    if (is_blank(c)) begin
      if (c == NL && line_count != stl_pkg::LINE_TOP) line_count++;
      return;
    end
    token_line = line_count;
    for (k = 0; k < 11; k++) begin
      if (punct_ch[k] == c) begin
        add_token(stl_pkg::KIND_W'(k + 1), line_count);
        return;
      end
    end
    for (k = 0; k < 6; k++) begin
      if (op_ch[k] == c) begin
        op_held  = 3'(k);
        lex_mode = LEX_OP;
        return;
      end
    end
    if (c == "\"" || c == "'") begin
      quote_single = (c == "'");
      lex_mode     = LEX_STR;
      return;
    end
    word_len = 0;
    add_to_word(c);
    lex_mode = LEX_WORD;
  endtask

  task automatic lex_predict(input logic [7:0] c, input logic eot);
    logic [7:0] closer;
    item_tokens.delete();
    closer = quote_single ? "'" : "\"";
    if (eot || c == NUL) begin
      case (lex_mode)
        LEX_OP:   add_token(stl_pkg::KIND_W'(stl_pkg::K_OR + 2 * op_held), token_line);
        LEX_STR:  add_token(stl_pkg::K_STRLIT, token_line);
        LEX_WORD: add_token(classify_word(), token_line);
        default: ;
      endcase
      lex_mode = LEX_IDLE;
      add_token(stl_pkg::K_END, line_count);
    end else if (lex_mode == LEX_OP) begin
      lex_mode = LEX_IDLE;
      if (c == op_mate_ch[op_held]) begin
        add_token(stl_pkg::KIND_W'(stl_pkg::K_OR + 1 + 2 * op_held), token_line);
      end else begin
        add_token(stl_pkg::KIND_W'(stl_pkg::K_OR + 2 * op_held), token_line);
        start_token(c);
      end
    end else if (lex_mode == LEX_STR) begin
      if (c == closer) begin
        add_token(stl_pkg::K_STRLIT, token_line);
        lex_mode = LEX_IDLE;
      end else if (c == NL && line_count != stl_pkg::LINE_TOP) begin
        line_count++;
      end
    end else if (lex_mode == LEX_WORD) begin
      if (is_alnum_ch(c)) begin
        add_to_word(c);
      end else begin
        add_token(classify_word(), token_line);
        lex_mode = LEX_IDLE;
        start_token(c);
      end
    end else begin
      start_token(c);
    end
    if (item_tokens.size() > 0) item_tokens[item_tokens.size() - 1].last = 1'b1;
    foreach (item_tokens[k]) tokens_due.push_back(item_tokens[k]);
  endtask

  task automatic send_item(input logic [7:0] c, input logic eot);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      chars_if.valid       <= 1'b0;
      chars_if.ch          <= 8'($urandom);
      chars_if.end_of_text <= 1'($urandom);
    end
    @(negedge clk);
    chars_if.valid       <= 1'b1;
    chars_if.ch          <= c;
    chars_if.end_of_text <= eot;
    do @(posedge clk); while (!chars_if.ready);
    lex_predict(c, eot);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  function automatic logic [7:0] rand_letter();
    return $urandom_range(0, 1) ? 8'($urandom_range("a", "z")) : 8'($urandom_range("A", "Z"));
  endfunction

  function automatic logic [7:0] rand_alnum();
    return $urandom_range(0, 2) == 0 ? 8'($urandom_range("0", "9")) : rand_letter();
  endfunction

  // one well-formed token, a separator, an end marker or a stray byte
  task automatic send_snippet();
    logic [7:0] bytes_q [$];
    logic [7:0] q;
    string      w;
    int         pick;
    int         n;
    int         k;
    pick = $urandom_range(0, 99);
    if (pick < 18) begin
      w = kw_words[$urandom_range(0, 11)];
      for (k = 0; k < w.len(); k++) bytes_q.push_back(w[k]);
      if ($urandom_range(0, 9) == 0) bytes_q[0] = bytes_q[0] - 8'd32;
      if ($urandom_range(0, 9) == 0) bytes_q.push_back(rand_alnum());
    end else if (pick < 32) begin
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 6);
      bytes_q.push_back(($urandom_range(0, 7) == 0) ? 8'($urandom_range(128, 255))
                                                    : rand_letter());
      repeat (n - 1) bytes_q.push_back(rand_alnum());
    end else if (pick < 44) begin
      case ($urandom_range(0, 3))
        0: begin
          bytes_q.push_back(8'($urandom_range("0", "9")));
          repeat ($urandom_range(0, 4)) bytes_q.push_back(rand_alnum());
        end
        1: begin
          bytes_q.push_back(".");
          if ($urandom_range(0, 3) != 0)
            bytes_q.push_back($urandom_range(0, 1) ? 8'($urandom_range("0", "9"))
                                                   : rand_letter());
        end
        2: begin
          w = $urandom_range(0, 1) ? "inf" : "nan";
          n = ($urandom_range(0, 3) == 0) ? 2 : 3;
          for (k = 0; k < n; k++)
            bytes_q.push_back($urandom_range(0, 1) ? w[k] : w[k] - 8'd32);
          if ($urandom_range(0, 2) == 0) bytes_q.push_back(rand_alnum());
        end
        default: repeat ($urandom_range(9, 14)) bytes_q.push_back(8'($urandom_range("0", "9")));
      endcase
    end else if (pick < 56) begin
      bytes_q.push_back(punct_ch[$urandom_range(0, 10)]);
    end else if (pick < 70) begin
      k = $urandom_range(0, 5);
      bytes_q.push_back(op_ch[k]);
      if ($urandom_range(0, 1)) bytes_q.push_back(op_mate_ch[k]);
    end else if (pick < 80) begin
      q = $urandom_range(0, 1) ? "'" : "\"";
      bytes_q.push_back(q);
      repeat ($urandom_range(0, 6)) begin
        case ($urandom_range(0, 5))
          0:       bytes_q.push_back(NL);
          1:       bytes_q.push_back(q == "'" ? "\"" : "'");
          2:       bytes_q.push_back(8'($urandom_range(1, 255)));
          3:       bytes_q.push_back(8'h20);
          default: bytes_q.push_back(rand_alnum());
        endcase
      end
      if ($urandom_range(0, 6) != 0) bytes_q.push_back(q);
    end else if (pick < 92) begin
      repeat ($urandom_range(1, 3)) bytes_q.push_back(blank_ch[$urandom_range(0, 5)]);
    end else if (pick < 97) begin
      bytes_q.push_back(8'($urandom_range(1, 255)));
    end
    foreach (bytes_q[i]) send_item(bytes_q[i], 1'b0);
    if (pick >= 97) begin
      if ($urandom_range(0, 1)) send_item(8'($urandom), 1'b1);
      else send_item(NUL, 1'b0);
    end else if ($urandom_range(0, 9) < 4) begin
      send_item($urandom_range(0, 2) == 0 ? NL : 8'h20, 1'b0);
    end
  endtask

  task automatic test_end_markers();
    send_item(8'hff, 1'b1);
    send_text("<");
    send_item(NUL, 1'b1);
    send_text("\"a");
    send_item(NL, 1'b0);
    send_item(NUL, 1'b0);
    send_text("nAn");
    send_item("=", 1'b1);
  endtask

  task automatic test_high_bytes();
    send_item(8'hff, 1'b0);
    send_item(8'h80, 1'b0);
    send_text("!=");
    send_item(8'h00, 1'b1);
  endtask

  task automatic test_literals_and_pairs();
    send_text("9x'q\"'==");
    send_item(8'hff, 1'b1);
  endtask

  task automatic test_random_source();
    int target;
    target = items_sent + 1350;
    while (items_sent < target) begin
      quiet = ($urandom_range(0, 9) == 0);
      repeat ($urandom_range(5, 30)) send_snippet();
    end
    quiet = 1'b0;
  endtask

  // newlines between tokens and inside literals move the line number
  task automatic test_line_counting();
    send_text("a\n\"\n\n\"\nb");
    send_item(NL, 1'b0);
    send_text("x'\n");
    send_item(8'h00, 1'b1);
    repeat (20) send_snippet();
  endtask

  task automatic wait_drained();
    int spin;
    spin = 0;
    while (tokens_due.size() > 0 && spin < 5000) begin
      @(posedge clk);
      spin++;
    end
    repeat (8) @(posedge clk);
    if (tokens_due.size() > 0) report_mismatch("tokens never arrived", 0, tokens_due.size());
  endtask

  // receiver side with random stalls
  initial begin
    int hold;
    tok_if.ready = 1'b0;
    forever begin
      hold = pick_gap();
      repeat (hold) begin
        @(negedge clk);
        tok_if.ready <= 1'b0;
      end
      @(negedge clk);
      tok_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : token_check
    stl_pkg::token_t want;
    if (!rst && tok_if.valid && tok_if.ready) begin
      if (tokens_due.size() == 0) begin
        report_mismatch("token with none due, kind", tok_if.token_kind, -1);
      end else begin
        want = tokens_due.pop_front();
        if (tok_if.token_kind !== want.kind)
          report_mismatch("token_kind", tok_if.token_kind, want.kind);
        if (tok_if.line !== want.line) report_mismatch("line", tok_if.line, want.line);
        if (tok_if.last !== want.last) report_mismatch("last", tok_if.last, want.last);
      end
    end
  end

  initial begin
    rst                  = 1'b1;
    chars_if.valid       = 1'b0;
    chars_if.ch          = 8'h00;
    chars_if.end_of_text = 1'b0;
    errors       = 0;
    items_sent   = 0;
    quiet        = 1'b0;
    lex_mode     = LEX_IDLE;
    op_held      = '0;
    quote_single = 1'b0;
    word_len     = 0;
    line_count   = '0;
    token_line   = '0;
    foreach (word_buf[i]) word_buf[i] = 8'h00;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_end_markers();
    test_high_bytes();
    test_literals_and_pairs();
    test_random_source();
    test_line_counting();

    @(negedge clk);
    chars_if.valid <= 1'b0;
    wait_drained();
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/stl_pkg.sv
rtl/stl_in_if.sv
rtl/stl_tok_if.sv
rtl/stl_front.sv
rtl/stl_queue.sv
rtl/stl_back.sv
rtl/source_token_lexer.sv
bench/tb_top.sv
